// ===== rtl/sws_pkg.sv =====
// Shared constants, types and codes for the sliding window statistics unit.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package sws_pkg;
    localparam int WINDOW       = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int CMD_BITS     = 2;
    localparam int IDX_BITS     = 4;
    localparam int CNT_BITS     = 5;
    localparam int SUM_BITS     = 20;
    localparam int NUM_BITS     = 24;
    localparam int MEAN_BITS    = 20;
    localparam int MED_BITS     = 17;
    localparam int DIV_STEPS    = 6;
    localparam int DIV_CYCLES   = NUM_BITS / DIV_STEPS;
    localparam int DIV_CNT_BITS = 2;
    localparam int REM_BITS     = CNT_BITS + 1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_SPARE = 2'd3
    } t_cmd;

    // One cell's view of a neighbor in the sorted chain.
    typedef struct packed {
        logic    valid;
        t_sample value;
    } t_cell_link;

    // Operation broadcast to every sorted cell.
    typedef struct packed {
        logic    clear;
        logic    del;
        logic    ins;
        t_sample key;
    } t_sort_op;
endpackage
`default_nettype wire

// ===== rtl/sws_if.sv =====
// Valid/ready channel interfaces for the input and result beats.
// Depends on sws_pkg.
`default_nettype none
interface sws_in_if;
    logic                             valid;
    logic                             ready;
    logic [sws_pkg::CMD_BITS-1:0]     cmd;
    logic signed [sws_pkg::SAMPLE_BITS-1:0] sample;
    logic [sws_pkg::IDX_BITS-1:0]     age_index;
    modport source (output valid, cmd, sample, age_index, input ready);
    modport sink   (input valid, cmd, sample, age_index, output ready);
endinterface

interface sws_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [sws_pkg::CNT_BITS-1:0]           fill_count;
    logic                                   is_empty;
    logic signed [sws_pkg::SAMPLE_BITS-1:0] min_value;
    logic signed [sws_pkg::SAMPLE_BITS-1:0] max_value;
    logic signed [sws_pkg::MEAN_BITS-1:0]   mean_x16;
    logic signed [sws_pkg::MED_BITS-1:0]    median_x2;
    logic signed [sws_pkg::SAMPLE_BITS-1:0] aged_value;
    logic                                   aged_valid;
    modport source (output valid, fill_count, is_empty, min_value, max_value, mean_x16,
                    median_x2, aged_value, aged_valid, input ready);
    modport sink   (input valid, fill_count, is_empty, min_value, max_value, mean_x16,
                    median_x2, aged_value, aged_valid, output ready);
endinterface
`default_nettype wire

// ===== rtl/sliding_window_statistics_unit.sv =====
// Top level of the sliding window statistics unit: sorted chain, age chain,
// mean divider and result register. Depends on sws_pkg, sws_if, sws_sort_cell,
// sws_age_cell and sws_div.
//
//   channel | dir | beat contents
//   i_in    | in  | cmd, sample, age_index
//   o_out   | out | fill_count, is_empty, min/max, mean_x16, median_x2, aged value/valid
//
// One item at a time. Query or clear: accept, start the mean divider, wait for it,
// then load the result register; push first adds a sorted-chain insert step, and
// a delete step before that once full. The mean divider takes 6 quotient bits per cycle.
// Synchronous active-low reset empties the sorted chain and the count; the age chain is not reset.
// A result waiting on a stalled o_out holds the finished item; the next beat is
// taken as soon as the result register is loaded.
`default_nettype none
module sliding_window_statistics_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sws_in_if.sink     i_in,
    sws_out_if.source  o_out
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DEL   = 6'b000010,
        ST_INS   = 6'b000100,
        ST_START = 6'b001000,
        ST_WAIT  = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    localparam int W = sws_pkg::WINDOW;

    t_state r_state, n_state;

    logic [sws_pkg::CNT_BITS-1:0]  r_count;
    logic signed [sws_pkg::SUM_BITS-1:0] r_sum;
    sws_pkg::t_sample              r_sample;
    sws_pkg::t_sample              r_old;
    logic [sws_pkg::IDX_BITS-1:0]  r_age;
    logic                          r_neg;

    // result register
    logic                                   r_out_valid;
    logic [sws_pkg::CNT_BITS-1:0]           r_fill;
    logic                                   r_empty;
    sws_pkg::t_sample                       r_min, r_max, r_aged;
    logic signed [sws_pkg::MEAN_BITS-1:0]   r_mean;
    logic signed [sws_pkg::MED_BITS-1:0]    r_med;
    logic                                   r_aged_ok;

    logic accept, is_push, is_clear, full;
    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign is_push  = (i_in.cmd == sws_pkg::CMD_PUSH);
    assign is_clear = (i_in.cmd == sws_pkg::CMD_CLEAR);
    assign full     = (r_count == sws_pkg::CNT_BITS'(W));

    // ---------------- age chain ----------------
    sws_pkg::t_sample age_val [W];
    sws_pkg::t_sample age_tap [W];
    logic             age_shift;
    assign age_shift = accept && is_push;

    for (genvar g = 0; g < W; g++) begin : g_age
        sws_age_cell u_age (
            .i_clk   (i_clk),
            .i_shift (age_shift),
            .i_prev  ((g == 0) ? sws_pkg::t_sample'(i_in.sample) : age_val[(g == 0) ? 0 : g-1]),
            .i_sel   (r_age == sws_pkg::IDX_BITS'(g)),
            .o_value (age_val[g]),
            .o_tap   (age_tap[g])
        );
    end

    // ---------------- sorted chain ----------------
    sws_pkg::t_cell_link srt [W];
    sws_pkg::t_sort_op   op;
    sws_pkg::t_cell_link head_link, tail_link;
    logic [W-1:0]        srt_valid;

    assign op.clear = accept && is_clear;
    assign op.del   = (r_state == ST_DEL);
    assign op.ins   = (r_state == ST_INS);
    assign op.key   = (r_state == ST_DEL) ? r_old : r_sample;

    // below the head sits a valid most-negative value, so an insert can land at cell 0
    assign head_link.valid = 1'b1;
    assign head_link.value = {1'b1, {(sws_pkg::SAMPLE_BITS-1){1'b0}}};
    assign tail_link.valid = 1'b0;
    assign tail_link.value = '0;

    for (genvar g = 0; g < W; g++) begin : g_sort
        sws_sort_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (op),
            .i_prev  ((g == 0) ? head_link : srt[(g == 0) ? 0 : g-1]),
            .i_next  ((g == W-1) ? tail_link : srt[(g == W-1) ? W-1 : g+1]),
            .o_link  (srt[g])
        );
        assign srt_valid[g] = srt[g].valid;
    end

    // ---------------- mean divider ----------------
    logic signed [sws_pkg::NUM_BITS-1:0] num_s;
    logic [sws_pkg::NUM_BITS-1:0]        num_mag;
    logic [sws_pkg::NUM_BITS-1:0]        quot;
    logic                                div_done;

    assign num_s   = {r_sum, 4'b0000};
    // floor for negatives: -ceil(|a| / n)
    assign num_mag = num_s[sws_pkg::NUM_BITS-1] ?
                     (-num_s) + sws_pkg::NUM_BITS'(r_count) - 1'b1 : num_s;

    sws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_START),
        .i_num   (num_mag),
        .i_den   (r_count),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // ---------------- statistics from the chains ----------------
    logic [sws_pkg::CNT_BITS-1:0] idx_max, idx_lo, idx_hi;
    sws_pkg::t_sample             v_max, v_lo, v_hi, v_aged;
    logic signed [sws_pkg::MED_BITS-1:0] med_sum;
    logic [sws_pkg::NUM_BITS-1:0]        mean_full;
    logic                                empty, aged_ok;

    assign empty   = (r_count == '0);
    assign idx_max = r_count - 1'b1;
    assign idx_lo  = idx_max >> 1;
    assign idx_hi  = r_count >> 1;
    assign aged_ok = ({1'b0, r_age} < r_count);

    always_comb begin
        v_max  = '0;
        v_lo   = '0;
        v_hi   = '0;
        v_aged = '0;
        for (int i = 0; i < W; i++) begin
            if (idx_max == sws_pkg::CNT_BITS'(i)) v_max = v_max | srt[i].value;
            if (idx_lo  == sws_pkg::CNT_BITS'(i)) v_lo  = v_lo  | srt[i].value;
            if (idx_hi  == sws_pkg::CNT_BITS'(i)) v_hi  = v_hi  | srt[i].value;
            v_aged = v_aged | age_tap[i];
        end
    end

    assign med_sum   = sws_pkg::MED_BITS'(v_lo) + sws_pkg::MED_BITS'(v_hi);
    assign mean_full = r_neg ? -quot : quot;

    // ---------------- control ----------------
    logic out_free;
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (is_push) n_state = full ? ST_DEL : ST_INS;
                    else         n_state = ST_START;
                end
            end
            ST_DEL:   n_state = ST_INS;
            ST_INS:   n_state = ST_START;
            ST_START: n_state = ST_WAIT;
            ST_WAIT:  if (div_done) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if (is_push) begin
                    if (!full) r_count <= r_count + 1'b1;
                    r_sum <= r_sum + sws_pkg::SUM_BITS'(i_in.sample)
                           - (full ? sws_pkg::SUM_BITS'(age_val[W-1]) : '0);
                end else if (is_clear) begin
                    r_count <= '0;
                    r_sum   <= '0;
                end
            end
            if ((r_state == ST_DONE) && out_free) r_out_valid <= 1'b1;
            else if (o_out.valid && o_out.ready) r_out_valid <= 1'b0;
        end
        if (accept) begin
            r_sample <= i_in.sample;
            r_old    <= age_val[W-1];
            r_age    <= i_in.age_index;
        end
        if (r_state == ST_START) r_neg <= r_sum[sws_pkg::SUM_BITS-1];
        if ((r_state == ST_DONE) && out_free) begin
            r_fill    <= r_count;
            r_empty   <= empty;
            r_min     <= empty ? '0 : srt[0].value;
            r_max     <= empty ? '0 : v_max;
            r_mean    <= empty ? '0 : mean_full[sws_pkg::MEAN_BITS-1:0];
            r_med     <= empty ? '0 : med_sum;
            r_aged    <= aged_ok ? v_aged : '0;
            r_aged_ok <= aged_ok;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.fill_count = r_fill;
    assign o_out.is_empty   = r_empty;
    assign o_out.min_value  = r_min;
    assign o_out.max_value  = r_max;
    assign o_out.mean_x16   = r_mean;
    assign o_out.median_x2  = r_med;
    assign o_out.aged_value = r_aged;
    assign o_out.aged_valid = r_aged_ok;

    // ---------------- assertions ----------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sws_pkg::CNT_BITS'(W))
        else $error("fill count above window");

    a_chain_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_START) |-> ($countones(srt_valid) == int'(r_count)))
        else $error("sorted chain occupancy differs from fill count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("accepted beat did not start work");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.is_empty) |-> (o_out.min_value <= o_out.max_value))
        else $error("minimum above maximum");
endmodule
`default_nettype wire

// ===== rtl/sws_sort_cell.sv =====
// One cell of the sorted chain: ascending order, invalid cells sit on top.
// Depends on sws_pkg.
`default_nettype none
module sws_sort_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sws_pkg::t_sort_op   i_op,
    input  wire sws_pkg::t_cell_link i_prev,
    input  wire sws_pkg::t_cell_link i_next,
    output sws_pkg::t_cell_link      o_link
);
    logic             r_valid;
    sws_pkg::t_sample r_value;
    logic             n_valid;
    sws_pkg::t_sample n_value;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_op.clear) begin
            n_valid = 1'b0;
        end else if (i_op.del) begin
            // everything at or above the removed key slides down one place
            if (r_valid && (r_value >= i_op.key)) begin
                n_valid = i_next.valid;
                n_value = i_next.value;
            end
        end else if (i_op.ins) begin
            if (r_valid || i_prev.valid) begin
                if (!r_valid || (r_value > i_op.key)) begin
                    n_valid = 1'b1;
                    n_value = (i_prev.valid && (i_prev.value > i_op.key)) ?
                              i_prev.value : i_op.key;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_link.valid = r_valid;
    assign o_link.value = r_value;
endmodule
`default_nettype wire

// ===== rtl/sws_age_cell.sv =====
// One cell of the age chain, newest at the head; gives its sample when selected.
// Depends on sws_pkg.
`default_nettype none
module sws_age_cell (
    input  wire logic             i_clk,
    input  wire logic             i_shift,
    input  wire sws_pkg::t_sample i_prev,
    input  wire logic             i_sel,
    output sws_pkg::t_sample      o_value,
    output sws_pkg::t_sample      o_tap
);
    sws_pkg::t_sample r_value;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_prev;
        end
    end

    assign o_value = r_value;
    assign o_tap   = i_sel ? r_value : '0;
endmodule
`default_nettype wire

// ===== rtl/sws_div.sv =====
// Unsigned restoring divider, several quotient bits per cycle.
// Depends on sws_pkg.
`default_nettype none
module sws_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sws_pkg::NUM_BITS-1:0]  i_num,
    input  wire logic [sws_pkg::CNT_BITS-1:0]  i_den,
    output logic                               o_done,
    output logic [sws_pkg::NUM_BITS-1:0]       o_quot
);
    logic                              r_busy;
    logic                              r_done;
    logic [sws_pkg::DIV_CNT_BITS-1:0]  r_cnt;
    logic [sws_pkg::REM_BITS-1:0]      r_rem;
    logic [sws_pkg::NUM_BITS-1:0]      r_quo;
    logic [sws_pkg::CNT_BITS-1:0]      r_den;
    logic [sws_pkg::REM_BITS-1:0]      n_rem;
    logic [sws_pkg::NUM_BITS-1:0]      n_quo;

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < sws_pkg::DIV_STEPS; k++) begin
            n_rem = {n_rem[sws_pkg::REM_BITS-2:0], n_quo[sws_pkg::NUM_BITS-1]};
            n_quo = {n_quo[sws_pkg::NUM_BITS-2:0], 1'b0};
            if (n_rem >= {1'b0, r_den}) begin
                n_rem    = n_rem - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy &&
                      (r_cnt == sws_pkg::DIV_CNT_BITS'(sws_pkg::DIV_CYCLES - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sws_pkg::DIV_CNT_BITS'(sws_pkg::DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule
`default_nettype wire

// ===== verif/sws_checker.sv =====
// Scoreboard for the sliding window statistics unit: watches both channels,
// predicts each result beat and compares it field by field. Depends on sws_pkg, sws_if.
`timescale 1ns / 1ps
module sws_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sws_in_if.sink    i_in_mon,
    sws_out_if.sink   i_out_mon,
    output int        o_fail_count,
    output int        o_pending
);
    typedef struct packed {
        logic [sws_pkg::CNT_BITS-1:0]  fill_count;
        logic                          is_empty;
        sws_pkg::t_sample              min_value;
        sws_pkg::t_sample              max_value;
        logic [sws_pkg::MEAN_BITS-1:0] mean_x16;
        logic [sws_pkg::MED_BITS-1:0]  median_x2;
        sws_pkg::t_sample              aged_value;
        logic                          aged_valid;
    } t_stats;

    sws_pkg::t_sample history [sws_pkg::WINDOW];
    int      held;
    t_stats  stats_q [$];
    int      fails = 0;

    assign o_fail_count = fails;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    // Applies one input beat to the shadow window and returns the statistics.
    function automatic t_stats window_stats(input logic [sws_pkg::CMD_BITS-1:0] cmd,
                                            input sws_pkg::t_sample smp, input int age);
        t_stats r;
        longint srt [sws_pkg::WINDOW];
        longint total, v, mn, mx, q, med;
        int j;
        if (cmd == sws_pkg::CMD_PUSH) begin
            if (held < sws_pkg::WINDOW) held++;
            for (int i = sws_pkg::WINDOW - 1; i > 0; i--) history[i] = history[i-1];
            history[0] = smp;
        end else if (cmd == sws_pkg::CMD_CLEAR) begin
            held = 0;
        end
        r = '0;
        r.fill_count = sws_pkg::CNT_BITS'(held);
        r.is_empty = (held == 0);
        if (held > 0) begin
            mn = history[0];
            mx = history[0];
            total = 0;
            for (int i = 0; i < held; i++) begin
                v = history[i];
                if (v < mn) mn = v;
                if (v > mx) mx = v;
                total += v;
                j = i;
                while (j > 0 && srt[j-1] > v) begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = v;
            end
            q = (total * 16) / held;
            if (((total * 16) % held) != 0 && total < 0) q--;
            med = (held % 2) ? 2 * srt[(held-1)/2] : srt[held/2] + srt[held/2-1];
            r.min_value = sws_pkg::SAMPLE_BITS'(mn);
            r.max_value = sws_pkg::SAMPLE_BITS'(mx);
            r.mean_x16  = sws_pkg::MEAN_BITS'(q);
            r.median_x2 = sws_pkg::MED_BITS'(med);
        end
        r.aged_valid = age < held;
        if (r.aged_valid) r.aged_value = history[age];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_stats e;
        if (!i_rst_n) begin
            held = 0;
            stats_q.delete();
            fails = 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (stats_q.size() == 0) begin
                    report("unexpected beat", 0, 0);
                end else begin
                    e = stats_q.pop_front();
                    if (i_out_mon.fill_count !== e.fill_count)
                        report("fill_count", i_out_mon.fill_count, e.fill_count);
                    if (i_out_mon.is_empty !== e.is_empty)
                        report("is_empty", i_out_mon.is_empty, e.is_empty);
                    if (i_out_mon.min_value !== e.min_value)
                        report("min_value", i_out_mon.min_value, e.min_value);
                    if (i_out_mon.max_value !== e.max_value)
                        report("max_value", i_out_mon.max_value, e.max_value);
                    if (i_out_mon.mean_x16 !== e.mean_x16)
                        report("mean_x16", i_out_mon.mean_x16, e.mean_x16);
                    if (i_out_mon.median_x2 !== e.median_x2)
                        report("median_x2", i_out_mon.median_x2, e.median_x2);
                    if (i_out_mon.aged_value !== e.aged_value)
                        report("aged_value", i_out_mon.aged_value, e.aged_value);
                    if (i_out_mon.aged_valid !== e.aged_valid)
                        report("aged_valid", i_out_mon.aged_valid, e.aged_valid);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                stats_q.push_back(window_stats(i_in_mon.cmd, i_in_mon.sample,
                                               i_in_mon.age_index));
        end
        o_pending = stats_q.size();
    end
endmodule

// ===== verif/tb.sv =====
// Testbench top for the sliding window statistics unit: clock, reset, stimulus,
// watchdog and verdict. Depends on sws_pkg, sws_if, sws_checker and the RTL.
`timescale 1ns / 1ps
module tb;
    localparam int STALL_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending;
    int   idle_cycles = 0;
    bit   calm;     // no idling on either side while set

    sws_in_if  in_ch ();
    sws_out_if out_ch ();

    sliding_window_statistics_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    sws_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch.sink),
        .i_out_mon    (out_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side backpressure, changed at the falling edge.
    always @(negedge i_clk)
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);

    // Watchdog: cycles with no beat on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Drives one beat and holds it until accepted; an idle gap may come first.
    // valid drops only for a gap, so back-to-back beats keep it high.
    task automatic send_beat(input logic [sws_pkg::CMD_BITS-1:0] cmd,
                             input sws_pkg::t_sample smp,
                             input logic [sws_pkg::IDX_BITS-1:0] age);
        while (!calm && $urandom_range(99) < 30) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.sample <= smp;
        in_ch.age_index <= age;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic logic [sws_pkg::CMD_BITS-1:0] pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 70) return sws_pkg::CMD_PUSH;
        if (r < 75) return sws_pkg::CMD_CLEAR;
        if (r < 95) return sws_pkg::CMD_QUERY;
        return sws_pkg::CMD_SPARE;
    endfunction

    initial begin
        in_ch.valid = 1'b0;
        in_ch.cmd = sws_pkg::CMD_QUERY;
        in_ch.sample = '0;
        in_ch.age_index = '0;
        calm = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty window, extremes, wrap past full, clear, spare code.
        send_beat(sws_pkg::CMD_QUERY, 16'sd0, 4'd0);
        send_beat(sws_pkg::CMD_PUSH, 16'sh8000, 4'd0);
        send_beat(sws_pkg::CMD_PUSH, 16'sd32767, 4'd1);
        send_beat(sws_pkg::CMD_SPARE, 16'sd5, 4'd2);
        for (int i = 0; i < 16; i++)
            send_beat(sws_pkg::CMD_PUSH, (i % 2) ? 16'sh8000 : -16'sd1, 4'(15 - i));
        send_beat(sws_pkg::CMD_QUERY, 16'sd0, 4'd15);
        send_beat(sws_pkg::CMD_CLEAR, 16'sd100, 4'd15);
        send_beat(sws_pkg::CMD_PUSH, -16'sd3, 4'd0);

        // Hold off until the checker has seen every result.
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        for (int n = 0; n < 1750; n++) begin
            sws_pkg::t_sample s;
            calm = (n >= 600 && n < 800);
            case ($urandom_range(3))
                0: s = sws_pkg::t_sample'(int'($urandom_range(7)) - 4);
                1: s = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
                default: s = sws_pkg::t_sample'($urandom);
            endcase
            send_beat(pick_cmd(), s, sws_pkg::IDX_BITS'($urandom_range(15)));
        end

        calm = 1'b0;
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
